FILE: hdl/lzfb_pkg.sv
package lzfb_pkg;

    // Parser constants
    localparam int unsigned FLAG_ITEMS = 8;      // items governed by one flag byte
    localparam int unsigned LEN_BIAS   = 3;      // code length = high nibble + 3
    localparam int unsigned DIST_W     = 12;     // code distance field (distance - 1)
    localparam int unsigned LEN_W      = 5;      // holds 1 to 18
    localparam logic [7:0]  LEN_MASK   = 8'hF0;
    localparam logic [7:0]  DIST_MASK  = 8'h0F;

    // Command queue between parser and copy engine
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    // One command: a literal (lo holds the byte) or a copy (lo/hi hold the code)
    typedef struct packed {
        logic       is_copy;
        logic [7:0] hi;
        logic [7:0] lo;
    } t_cmd;

    // Where the byte in the read stage comes from
    typedef enum logic [1:0] {
        SRC_RAM  = 2'd0,
        SRC_LIT  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_FWD  = 2'd3
    } t_src;

endpackage

FILE: hdl/lzfb_ram.sv
module lzfb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lzfb_fifo.sv
module lzfb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lzfb_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lzfb_pkg::t_cmd o_data
);

    lzfb_pkg::t_cmd r_mem [lzfb_pkg::QUEUE_DEPTH];
    logic [lzfb_pkg::QUEUE_AW-1:0] r_wr;
    logic [lzfb_pkg::QUEUE_AW-1:0] r_rd;
    logic [lzfb_pkg::QUEUE_AW:0]   r_cnt;
    logic [lzfb_pkg::QUEUE_AW:0]   n_cnt;
    logic                          push_ok;
    logic                          pop_ok;

    assign o_full  = (r_cnt == (lzfb_pkg::QUEUE_AW + 1)'(lzfb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: hdl/lzfb_front.sv
module lzfb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,
    input  logic           s_axis_tlast,
    input  logic           i_q_full,
    output logic           o_push,
    output lzfb_pkg::t_cmd o_cmd
);

    logic [7:0] r_flags;
    logic [3:0] r_items;
    logic [7:0] r_code_low;
    logic       r_await;
    logic       accept;
    logic       want_flag;

    assign s_axis_tready = !i_q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign want_flag     = (r_items == '0);

    // a literal or the high byte of a code becomes one command
    assign o_push        = accept && !want_flag && (!r_flags[0] || r_await);
    assign o_cmd.is_copy = r_flags[0];
    assign o_cmd.hi      = s_axis_tdata;
    assign o_cmd.lo      = r_flags[0] ? r_code_low : s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags    <= '0;
            r_items    <= '0;
            r_code_low <= '0;
            r_await    <= 1'b0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                r_flags    <= '0;
                r_items    <= '0;
                r_code_low <= '0;
                r_await    <= 1'b0;
            end else if (want_flag) begin
                r_flags <= s_axis_tdata;
                r_items <= 4'(lzfb_pkg::FLAG_ITEMS);
                r_await <= 1'b0;
            end else if (!r_flags[0] || r_await) begin
                r_flags <= {1'b0, r_flags[7:1]};
                r_items <= r_items - 1'b1;
                r_await <= 1'b0;
            end else begin
                r_code_low <= s_axis_tdata;
                r_await    <= 1'b1;
            end
        end
    end

endmodule

FILE: hdl/lzfb_back.sv
module lzfb_back #(
    parameter int unsigned HISTORY_DEPTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  lzfb_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [7:0]     m_axis_tdata,
    output logic           m_axis_tlast
);

    localparam int unsigned AW      = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

    // active command
    logic                        r_act;
    logic                        r_is_copy;
    logic [7:0]                  r_lit;
    logic [lzfb_pkg::LEN_W-1:0]  r_len;
    logic [lzfb_pkg::DIST_W-1:0] r_dist;

    // read stage
    logic                 r_s1_vld;
    lzfb_pkg::t_src       r_s1_sel;
    logic [7:0]           r_s1_lit;
    logic                 r_s1_last;

    // output register
    logic       r_o_vld;
    logic [7:0] r_o_byte;
    logic       r_o_last;

    // history bookkeeping
    logic [AW-1:0] r_wp;
    logic [AW:0]   r_fill;
    logic [7:0]    r_prev;

    logic                 out_free;
    logic                 s1_move;
    logic [7:0]           s1_byte;
    logic [7:0]           ram_rdata;
    logic                 issue;
    logic                 done;
    logic                 load;
    logic [AW-1:0]        wp_inc;
    logic [AW-1:0]        wp_eff;
    logic [AW:0]          fill_inc;
    logic [AW:0]          fill_eff;
    logic [AW:0]          dist_ext;
    logic [AW:0]          src_diff;
    logic [AW:0]          src_wrap;
    logic [AW-1:0]        src;
    lzfb_pkg::t_src       n_sel;
    logic [lzfb_pkg::LEN_W-1:0] cmd_len;
    logic [7:0]           cmd_dist_hi;

    assign out_free  = !r_o_vld || m_axis_tready;
    assign s1_move   = r_s1_vld && out_free;
    assign issue     = r_act && (!r_s1_vld || s1_move);
    assign done      = issue && (r_len == lzfb_pkg::LEN_W'(1));
    assign load      = i_cmd_valid && (!r_act || done);
    assign o_cmd_pop = load;

    always_comb begin
        unique case (r_s1_sel)
            lzfb_pkg::SRC_RAM:  s1_byte = ram_rdata;
            lzfb_pkg::SRC_LIT:  s1_byte = r_s1_lit;
            lzfb_pkg::SRC_ZERO: s1_byte = 8'h00;
            lzfb_pkg::SRC_FWD:  s1_byte = r_prev;
            default:            s1_byte = 8'h00;
        endcase
    end

    // write pointer and fill count as they stand once the moving byte is written
    assign wp_inc   = (r_wp == WP_LAST) ? '0 : r_wp + 1'b1;
    assign wp_eff   = s1_move ? wp_inc : r_wp;
    assign fill_inc = (r_fill == DEPTH_W) ? r_fill : r_fill + 1'b1;
    assign fill_eff = s1_move ? fill_inc : r_fill;

    // source = write pointer - distance, modulo depth
    assign dist_ext = (AW + 1)'({1'b0, r_dist}) + 1'b1;
    assign src_diff = {1'b0, wp_eff} - dist_ext;
    assign src_wrap = src_diff + DEPTH_W;
    assign src      = src_diff[AW] ? src_wrap[AW-1:0] : src_diff[AW-1:0];

    always_comb begin
        if (!r_is_copy) begin
            n_sel = lzfb_pkg::SRC_LIT;
        end else if (r_dist == '0) begin
            n_sel = lzfb_pkg::SRC_FWD;     // distance one repeats the newest byte
        end else if (fill_eff < dist_ext) begin
            n_sel = lzfb_pkg::SRC_ZERO;    // reaches behind anything written
        end else begin
            n_sel = lzfb_pkg::SRC_RAM;
        end
    end

    assign cmd_len = i_cmd.is_copy
                   ? lzfb_pkg::LEN_W'((i_cmd.hi & lzfb_pkg::LEN_MASK) >> 4)
                     + lzfb_pkg::LEN_W'(lzfb_pkg::LEN_BIAS)
                   : lzfb_pkg::LEN_W'(1);

    assign cmd_dist_hi = i_cmd.hi & lzfb_pkg::DIST_MASK;

    lzfb_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_wp),
        .i_wdata (s1_byte),
        .i_re    (issue && (n_sel == lzfb_pkg::SRC_RAM)),
        .i_raddr (src),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_sel  <= n_sel;
            r_s1_lit  <= r_lit;
            r_s1_last <= (r_len == lzfb_pkg::LEN_W'(1));
            r_len     <= r_len - 1'b1;
        end
        if (load) begin
            r_is_copy <= i_cmd.is_copy;
            r_lit     <= i_cmd.lo;
            r_len     <= cmd_len;
            r_dist    <= {cmd_dist_hi[3:0], i_cmd.lo};
        end
        if (out_free) begin
            r_o_byte <= s1_byte;
            r_o_last <= r_s1_last;
        end
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_prev   <= '0;
        end else begin
            if (load) begin
                r_act <= 1'b1;
            end else if (done) begin
                r_act <= 1'b0;
            end
            if (issue) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (out_free) begin
                r_o_vld <= r_s1_vld;
            end
            if (s1_move) begin
                r_wp   <= wp_inc;
                r_fill <= fill_inc;
                r_prev <= s1_byte;
            end
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_byte;
    assign m_axis_tlast  = r_o_last;

endmodule

FILE: hdl/lz77_flag_byte_decompressor_unit.sv
// A literal or code goes via queue, active command, read stage and output register to m_axis.
// Throughput: one compressed byte per cycle in while the queue has room, one output byte per
//   cycle out while m_axis_tready allows; a copy of L bytes (3 to 18) holds the copy engine.
// Reset (synchronous, active low) clears parser, queue and pipeline; the history RAM is not
//   swept, a fill count makes bytes never written read as zero, so no start-up pass.
module lz77_flag_byte_decompressor_unit #(
    parameter int unsigned HISTORY_DEPTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // compressed stream in
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // last_in: ends the block, resets the parser
    // decompressed stream out
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // run_last: final byte caused by one input transfer
);

    // Front: flag/code parser, one command per literal or completed code.
    // Queue: a few commands, so the parser keeps taking bytes during long copies.
    // Back: copy engine, history RAM with registered read, output register.

    logic           q_full;
    logic           q_push;
    lzfb_pkg::t_cmd q_in;
    logic           q_valid;
    lzfb_pkg::t_cmd q_out;
    logic           q_pop;

    lzfb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    lzfb_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // run_last follows from each command ending: every input transfer yields
    // at most one command, and its final byte carries the mark.
    lzfb_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_out),
        .o_cmd_pop     (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: tb/lzfb_stream_checker.sv
`timescale 1ns / 100ps

module lzfb_stream_checker #(
    parameter int unsigned HIST_DEPTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,     // [7:0] in_byte
    input  logic       i_in_last,     // last_in
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,    // [7:0] out_byte
    input  logic       i_out_last,    // run_last
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
    } t_out_byte;

    t_out_byte   out_due[$];          // decoded bytes not yet seen on the output
    logic [7:0]  run_bytes[$];        // bytes decoded from one input transfer
    logic [7:0]  window [HIST_DEPTH];
    int unsigned wr_pos;
    logic [7:0]  flag_sr;             // unused flags, next one in bit 0
    logic [3:0]  items_left;          // 0: flag byte due
    logic [7:0]  code_lo;
    logic        hi_due;
    int          fails;
    t_out_byte   want;

    task automatic note_fail(input string msg);
        $display("%0t ns: %s", $time, msg);
        fails++;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        window[wr_pos] = b;
        wr_pos = (wr_pos + 1) % HIST_DEPTH;
        run_bytes.push_back(b);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic blk_end);
        int unsigned len;
        int unsigned back_dist;
        run_bytes.delete();
        if (items_left == 0) begin
            flag_sr = b;
            items_left = 4'(lzfb_pkg::FLAG_ITEMS);
            hi_due = 1'b0;
        end else if (!flag_sr[0]) begin
            emit_byte(b);
            flag_sr = flag_sr >> 1;
            items_left = items_left - 4'd1;
        end else if (!hi_due) begin
            code_lo = b;
            hi_due = 1'b1;
        end else begin
            len       = 32'((b & lzfb_pkg::LEN_MASK) >> 4) + lzfb_pkg::LEN_BIAS;
            back_dist = (32'(b & lzfb_pkg::DIST_MASK) << 8) + 32'(code_lo) + 1;
            // byte-by-byte copy, so an overlapping source sees fresh bytes
            for (int unsigned k = 0; k < len; k++)
                emit_byte(window[(wr_pos + HIST_DEPTH - back_dist) % HIST_DEPTH]);
            hi_due = 1'b0;
            flag_sr = flag_sr >> 1;
            items_left = items_left - 4'd1;
        end
        foreach (run_bytes[i])
            out_due.push_back(t_out_byte'{data: run_bytes[i],
                                          run_end: (i == run_bytes.size() - 1)});
        if (blk_end) begin
            // block end drops a partial group; history survives
            flag_sr = '0;
            items_left = '0;
            code_lo = '0;
            hi_due = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++)
                window[i] = '0;
            out_due.delete();
            wr_pos = 0;
            flag_sr = '0;
            items_left = '0;
            code_lo = '0;
            hi_due = 1'b0;
            fails = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                decode_byte(i_in_data, i_in_last);
            if (i_out_valid && i_out_ready) begin
                if (out_due.size() == 0) begin
                    note_fail($sformatf("unexpected output byte %02h last %0b",
                                        i_out_data, i_out_last));
                end else begin
                    want = out_due.pop_front();
                    if (i_out_data !== want.data)
                        note_fail($sformatf("out_byte expected %02h, got %02h",
                                            want.data, i_out_data));
                    if (i_out_last !== want.run_end)
                        note_fail($sformatf("run_last expected %0b, got %0b (byte %02h)",
                                            want.run_end, i_out_last, want.data));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= out_due.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int ITEM_GOAL    = 260;
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off, fills the block
    localparam int HOLD_AFTER   = 100;    // transfers sent before the long hold-off
    localparam int PAUSE_AFTER  = 180;    // transfers sent before the mid-run drain
    localparam int STALL_LIMIT  = 4000;   // cycles without any transfer
    localparam int DRAIN_CYCLES = 24;     // after the last expected byte

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int fail_count;
    int pending;
    int n_sent       = 0;
    int quiet_cycles = 0;
    bit tx_eager     = 1'b0;   // sender offers back to back
    bit paused_mid   = 1'b0;

    // receiver state
    int rx_hold_left = 0;
    bit rx_hold_done = 1'b0;
    int rx_gap_left  = 0;
    int rx_mode_left = 0;
    bit rx_eager     = 1'b0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    lz77_flag_byte_decompressor_unit u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),    // [7:0] in_byte
        .s_axis_tlast  (s_tlast),    // last_in
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),    // [7:0] out_byte
        .m_axis_tlast  (m_tlast)     // run_last
    );

    // Decoder model and scoreboard; reports fails and bytes still due.
    lzfb_stream_checker #(.HIST_DEPTH(4096)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_last    (s_tlast),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_last   (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Sender idle length before a transfer: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (tx_eager)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One input transfer. tvalid stays high into the next call when there is no gap,
    // so it is never dropped and raised in the same step.
    task automatic put_item(input logic [7:0] b, input logic blk_end);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= blk_end;
        do @(posedge clk); while (!s_tready);
        n_sent++;
    endtask

    // Hold the input until every decoded byte has come out.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Receiver: random tready with eager stretches, plus one long hold-off
    // while the sender keeps offering, so the block backs up to its input.
    initial begin
        forever begin
            @(posedge clk);
            if (!rx_hold_done && n_sent >= HOLD_AFTER) begin
                rx_hold_left = HOLD_CYCLES;
                rx_hold_done = 1'b1;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (rx_gap_left > 0) begin
                rx_gap_left--;
                m_tready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_eager     = ($urandom_range(0, 2) == 0);
                    rx_mode_left = $urandom_range(50, 300);
                end else begin
                    rx_mode_left--;
                end
                if (!rx_eager && $urandom_range(0, 99) < 30) begin
                    rx_gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                               : $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[lz77_flag_byte_decompressor_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        logic [7:0]  flag;
        logic [11:0] dist_m1;
        logic [7:0]  blk[$];
        int          cut;
        int          r;
        int          n;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: group with literal, overlapping copy (distance 1),
        // max code (distance 4096, length 18) reading zeros before the first byte,
        // extreme literal values.
        put_item(8'h06, 1'b0);
        put_item(8'hFF, 1'b0);
        put_item(8'h00, 1'b0);
        put_item(8'h00, 1'b0);
        put_item(8'hFF, 1'b0);
        put_item(8'hFF, 1'b0);
        put_item(8'h00, 1'b0);
        put_item(8'hA5, 1'b0);
        put_item(8'h5A, 1'b0);
        put_item(8'h01, 1'b0);
        put_item(8'h80, 1'b0);
        // block end on a flag byte
        put_item(8'hFF, 1'b1);
        // block end on the low byte of a code: half code dropped
        put_item(8'h01, 1'b0);
        put_item(8'h02, 1'b1);
        // block end in mid group
        put_item(8'h00, 1'b0);
        put_item(8'h11, 1'b0);
        put_item(8'h22, 1'b1);
        // all-code group: distance 2 length 18, then distance 4 length 5 ending the block
        put_item(8'hFF, 1'b0);
        put_item(8'h01, 1'b0);
        put_item(8'hF0, 1'b0);
        put_item(8'h03, 1'b0);
        put_item(8'h20, 1'b1);

        // sender pause until everything is out
        drain_outputs();

        // Random: mostly well-formed blocks of 1..4 groups, some cut short at a random
        // byte, plus short bursts of noise.
        while (n_sent < ITEM_GOAL) begin
            tx_eager = ($urandom_range(0, 3) == 0);
            if (!paused_mid && n_sent >= PAUSE_AFTER) begin
                drain_outputs();
                paused_mid = 1'b1;
            end
            if ($urandom_range(0, 6) == 0) begin
                // noise: raw bytes, random block ends, always ending a block
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    put_item(8'($urandom), (i == n - 1) || ($urandom_range(0, 3) == 0));
            end else begin
                blk.delete();
                repeat ($urandom_range(1, 4)) begin
                    // flags lean toward codes so the output grows quickly
                    flag = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom | $urandom);
                    blk.push_back(flag);
                    for (int i = 0; i < 8; i++) begin
                        if (flag[i]) begin
                            r = $urandom_range(0, 99);
                            dist_m1 = (r < 50) ? 12'($urandom_range(0, 15)) :
                                      (r < 75) ? 12'($urandom_range(0, 255)) :
                                                 12'($urandom_range(0, 4095));
                            blk.push_back(dist_m1[7:0]);
                            blk.push_back({4'($urandom), dist_m1[11:8]});
                        end else begin
                            blk.push_back(8'($urandom));
                        end
                    end
                end
                cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, blk.size()) : blk.size();
                for (int i = 0; i < cut; i++)
                    put_item(blk[i], i == cut - 1);
            end
        end

        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[lz77_flag_byte_decompressor_unit] OK");
        else
            $display("[lz77_flag_byte_decompressor_unit] ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/lzfb_pkg.sv
hdl/lzfb_ram.sv
hdl/lzfb_fifo.sv
hdl/lzfb_front.sv
hdl/lzfb_back.sv
hdl/lz77_flag_byte_decompressor_unit.sv
tb/lzfb_stream_checker.sv
tb/tb.sv
